// ===== design/mbq_pkg.sv =====
// shared types and constants of the mouse button event qualifier
package mbq_pkg;

	localparam int BTN_FIELD_W = 3;
	localparam int ELAPSED_W   = 16;
	localparam int MOD_W       = 6;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_W-1:0] DCLICK_WINDOW_RESET = 16'd500;
	localparam logic [CFG_W-1:0] REPEAT_FIRST_RESET  = 16'd500;
	localparam logic [CFG_W-1:0] REPEAT_INTVL_RESET  = 16'd66;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DCLICK_WINDOW = 2'd0,
		REG_REPEAT_FIRST  = 2'd1,
		REG_REPEAT_INTVL  = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [BTN_FIELD_W-1:0] pressed_buttons;
		logic [ELAPSED_W-1:0]   elapsed_ms;
		logic                   keyboard_present;
		logic [MOD_W-1:0]       modifier_keys;
	} frame_t;

	typedef struct packed {
		logic [BTN_FIELD_W-1:0] held_mask;
		logic [BTN_FIELD_W-1:0] down_mask;
		logic [BTN_FIELD_W-1:0] up_mask;
		logic [BTN_FIELD_W-1:0] double_click_mask;
		logic [BTN_FIELD_W-1:0] repeat_mask;
		logic                   ctrl_held;
		logic                   alt_held;
		logic                   shift_held;
	} result_t;

	typedef struct packed {
		logic [CFG_W-1:0] double_click_window_ms;
		logic [CFG_W-1:0] repeat_first_delay_ms;
		logic [CFG_W-1:0] repeat_interval_ms;
	} cfg_t;

endpackage

// ===== design/mbq_if.sv =====
// valid/ready channel carrying one word of a given payload type
interface mbq_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== design/mbq_cfg_regs.sv =====
// configuration register file with write decode
module mbq_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mbq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mbq_pkg::CFG_W-1:0]       cfg_data,
	output mbq_pkg::cfg_t                   cfg
);
	mbq_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.double_click_window_ms <= mbq_pkg::DCLICK_WINDOW_RESET;
			cfg_q.repeat_first_delay_ms  <= mbq_pkg::REPEAT_FIRST_RESET;
			cfg_q.repeat_interval_ms     <= mbq_pkg::REPEAT_INTVL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mbq_pkg::REG_DCLICK_WINDOW: cfg_q.double_click_window_ms <= cfg_data;
				mbq_pkg::REG_REPEAT_FIRST:  cfg_q.repeat_first_delay_ms  <= cfg_data;
				mbq_pkg::REG_REPEAT_INTVL:  cfg_q.repeat_interval_ms     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// ===== design/mbq_engine.sv =====
// button state, timers and per-word event decision logic
module mbq_engine #(
	parameter int BUTTON_COUNT = 3,
	parameter int TIME_WIDTH   = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  mbq_pkg::frame_t   frame,
	input  mbq_pkg::cfg_t     cfg,
	output mbq_pkg::result_t  result
);
	localparam int LPB_W = $clog2(BUTTON_COUNT + 1);
	localparam int NMASK = 5;
	localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

	typedef logic [TIME_WIDTH-1:0] tm_t;

	function automatic tm_t sat_time(input logic [mbq_pkg::CFG_W-1:0] v);
		logic [31:0] v32;
		logic [31:0] m32;
		v32 = 32'(v);
		m32 = 32'(TIME_MAX);
		return (v32 > m32) ? TIME_MAX : v32[TIME_WIDTH-1:0];
	endfunction

	function automatic tm_t count_down(input tm_t t, input logic [mbq_pkg::ELAPSED_W-1:0] d);
		logic [31:0] t32;
		logic [31:0] d32;
		logic [31:0] diff;
		t32  = 32'(t);
		d32  = 32'(d);
		diff = t32 - d32;
		return (t32 > d32) ? diff[TIME_WIDTH-1:0] : '0;
	endfunction

	logic [BUTTON_COUNT-1:0] prev_q;
	logic [LPB_W-1:0]        lpb_q;
	tm_t                     dct_q;
	tm_t                     rep_q [BUTTON_COUNT];

	logic [BUTTON_COUNT-1:0] held_b;
	logic [BUTTON_COUNT-1:0] stroke;
	logic [BUTTON_COUNT-1:0] down_v;
	logic [BUTTON_COUNT-1:0] up_v;
	logic [BUTTON_COUNT-1:0] dclick_v;
	logic [BUTTON_COUNT-1:0] rep_v;
	logic [LPB_W-1:0]        lpb_n;
	tm_t                     dct_n;
	tm_t                     rep_n [BUTTON_COUNT];
	tm_t                     dc_load;
	tm_t                     first_load;
	tm_t                     intvl_load;
	logic [BUTTON_COUNT-1:0]        masks_b [NMASK];
	logic [mbq_pkg::BTN_FIELD_W-1:0] masks_o [NMASK];

	for (genvar i = 0; i < BUTTON_COUNT; i++) begin : g_held
		if (i < mbq_pkg::BTN_FIELD_W) begin : g_in
			assign held_b[i] = frame.pressed_buttons[i];
		end else begin : g_none
			assign held_b[i] = 1'b0;
		end
	end

	assign stroke     = ~prev_q & held_b;
	assign dc_load    = sat_time(cfg.double_click_window_ms);
	assign first_load = sat_time(cfg.repeat_first_delay_ms);
	assign intvl_load = sat_time(cfg.repeat_interval_ms);

	// buttons judged in index order, a lower press can restart the window
	always_comb begin
		lpb_n    = lpb_q;
		dct_n    = count_down(dct_q, frame.elapsed_ms);
		down_v   = '0;
		up_v     = '0;
		dclick_v = '0;
		rep_v    = '0;
		for (int i = 0; i < BUTTON_COUNT; i++) begin
			rep_n[i] = count_down(rep_q[i], frame.elapsed_ms);
			if (held_b[i]) begin
				if (stroke[i]) begin
					if (dct_n != '0 && lpb_n == LPB_W'(i + 1)) begin
						dclick_v[i] = 1'b1;
						lpb_n       = '0;
					end else begin
						down_v[i] = 1'b1;
						lpb_n     = LPB_W'(i + 1);
						dct_n     = dc_load;
					end
				end
				if (rep_n[i] == '0) begin
					rep_v[i] = 1'b1;
					rep_n[i] = stroke[i] ? first_load : intvl_load;
				end
			end else begin
				up_v[i]  = prev_q[i];
				rep_n[i] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			lpb_q  <= '0;
			dct_q  <= '0;
			for (int i = 0; i < BUTTON_COUNT; i++) begin
				rep_q[i] <= '0;
			end
		end else if (advance) begin
			prev_q <= held_b;
			lpb_q  <= lpb_n;
			dct_q  <= dct_n;
			for (int i = 0; i < BUTTON_COUNT; i++) begin
				rep_q[i] <= rep_n[i];
			end
		end
	end

	assign masks_b[0] = held_b;
	assign masks_b[1] = down_v;
	assign masks_b[2] = up_v;
	assign masks_b[3] = dclick_v;
	assign masks_b[4] = rep_v;

	for (genvar m = 0; m < NMASK; m++) begin : g_mask
		for (genvar j = 0; j < mbq_pkg::BTN_FIELD_W; j++) begin : g_bit
			if (j < BUTTON_COUNT) begin : g_used
				assign masks_o[m][j] = masks_b[m][j];
			end else begin : g_unused
				assign masks_o[m][j] = 1'b0;
			end
		end
	end

	assign result.held_mask         = masks_o[0];
	assign result.down_mask         = masks_o[1];
	assign result.up_mask           = masks_o[2];
	assign result.double_click_mask = masks_o[3];
	assign result.repeat_mask       = masks_o[4];
	assign result.ctrl_held  = frame.keyboard_present & (|frame.modifier_keys[1:0]);
	assign result.alt_held   = frame.keyboard_present & (|frame.modifier_keys[3:2]);
	assign result.shift_held = frame.keyboard_present & (|frame.modifier_keys[5:4]);
endmodule

// ===== design/mouse_button_event_qualifier.sv =====
// top level of the mouse button event qualifier
// Usage:
//   frames  : sink channel, one word per input frame (held buttons, elapsed
//             milliseconds, keyboard flag, modifier keys)
//   results : source channel, exactly one word per accepted frame, in order
//   cfg_we/cfg_index/cfg_data : register writes (double-click window, first
//             repeat delay, repeat interval); the user writes them only
//             while idle, a rule the block leaves to the user
// Throughput: one frame per cycle without result stalls; the event decision
//   is one pass of saturating subtract and compare logic between the input
//   and result registers, with the button state updated as a word advances.
// Reset: clears both pipeline stages, the button history, the last pressed
//   button and all timers; registers return to 500, 500 and 66 ms.
// Stall: a waiting result holds in the output register while one more
//   frame may enter the input register; after that frames.ready drops
//   until results.ready returns.
module mouse_button_event_qualifier #(
	parameter int BUTTON_COUNT = 3,
	parameter int TIME_WIDTH   = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	mbq_if.sink                            frames,
	mbq_if.source                          results,
	input  logic                           cfg_we,
	input  logic [mbq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mbq_pkg::CFG_W-1:0]      cfg_data
);
	mbq_pkg::cfg_t    cfg;
	mbq_pkg::frame_t  frame_s1;
	logic             valid_s1;
	mbq_pkg::result_t result_c;
	mbq_pkg::result_t result_s2;
	logic             valid_s2;
	logic             accept;
	logic             advance;

	mbq_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mbq_engine #(
		.BUTTON_COUNT (BUTTON_COUNT),
		.TIME_WIDTH   (TIME_WIDTH)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.frame   (frame_s1),
		.cfg     (cfg),
		.result  (result_c)
	);

	assign advance      = valid_s1 & (~valid_s2 | results.ready);
	assign frames.ready = ~valid_s1 | advance;
	assign accept       = frames.valid & frames.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (results.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			frame_s1 <= frames.payload;
		end
		if (advance) begin
			result_s2 <= result_c;
		end
	end

	assign results.valid   = valid_s2;
	assign results.payload = result_s2;
endmodule

// ===== design/mbq_checker.sv =====
// port-level assertions for the mouse button event qualifier, with bind
module mbq_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input mbq_pkg::result_t out_payload
);
	logic [mbq_pkg::BTN_FIELD_W-1:0] last_held_q;
	logic                            out_accept;

	assign out_accept = out_valid & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_held_q <= '0;
		end else if (out_accept) begin
			last_held_q <= out_payload.held_mask;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload))
		else $error("result word changed while stalled");

	a_up_after_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_accept |-> (out_payload.up_mask & ~last_held_q) == '0 &&
			(out_payload.up_mask & out_payload.held_mask) == '0)
		else $error("release without a prior held button");

	a_press_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_payload.down_mask | out_payload.double_click_mask) &
			~out_payload.held_mask) == '0 &&
			(out_payload.down_mask & out_payload.double_click_mask) == '0)
		else $error("press event inconsistent with held buttons");

	a_press_is_edge: assert property (@(posedge clk) disable iff (!arst_n)
		out_accept |-> ((out_payload.down_mask | out_payload.double_click_mask) &
			last_held_q) == '0)
		else $error("press event on a button already held");

	a_repeat_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_payload.repeat_mask & ~out_payload.held_mask) == '0)
		else $error("repeat event on a released button");
endmodule

bind mouse_button_event_qualifier mbq_checker u_mbq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.out_payload (results.payload)
);

// ===== bench/tb_mouse_button_event_qualifier.sv =====
`timescale 1ns / 1ps
// self-checking bench for the mouse button event qualifier against a frame predictor
module tb_mouse_button_event_qualifier;

	localparam logic [mbq_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [mbq_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [mbq_pkg::CFG_W-1:0]     cfg_data;

	mbq_if #(.payload_t(mbq_pkg::frame_t))  frames_ch ();
	mbq_if #(.payload_t(mbq_pkg::result_t)) results_ch ();

	mouse_button_event_qualifier i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.frames(frames_ch),
		.results(results_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor copy of registers and button state
	logic [mbq_pkg::CFG_W-1:0]     win_ms, first_ms, intvl_ms;
	logic [2:0]                    prev_btn;
	logic [1:0]                    last_btn;
	logic [mbq_pkg::ELAPSED_W-1:0] dclick_tmr;
	logic [mbq_pkg::ELAPSED_W-1:0] rep_tmr [3];

	mbq_pkg::frame_t  frame_q [$];
	mbq_pkg::result_t due_events [$];
	int unsigned      send_gap, sink_stall;
	bit               src_idle, sink_idle;
	int unsigned      mismatch_count, result_count, setting_count;
	int unsigned      n_down, n_up, n_dclick, n_repeat;
	logic [2:0]       stim_btn;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [mbq_pkg::ELAPSED_W-1:0] tick(
			input logic [mbq_pkg::ELAPSED_W-1:0] t,
			input logic [mbq_pkg::ELAPSED_W-1:0] dt);
		return (t > dt) ? t - dt : '0;
	endfunction

	function automatic mbq_pkg::result_t qualify_frame(input mbq_pkg::frame_t f);
		mbq_pkg::result_t r;
		logic [2:0]       held, old, stroke;
		r = '0;
		held = f.pressed_buttons;
		old = prev_btn;
		stroke = ~old & held;
		prev_btn = held;
		r.held_mask = held;
		dclick_tmr = tick(dclick_tmr, f.elapsed_ms);
		for (int i = 0; i < 3; i++)
			rep_tmr[i] = tick(rep_tmr[i], f.elapsed_ms);
		for (int i = 0; i < 3; i++) begin
			if (held[i]) begin
				if (stroke[i]) begin
					if (dclick_tmr != 0 && last_btn == 2'(i + 1)) begin
						r.double_click_mask[i] = 1'b1;
						last_btn = 2'd0;
					end else begin
						r.down_mask[i] = 1'b1;
						last_btn = 2'(i + 1);
						dclick_tmr = win_ms;
					end
				end
				if (rep_tmr[i] == 0) begin
					r.repeat_mask[i] = 1'b1;
					rep_tmr[i] = stroke[i] ? first_ms : intvl_ms;
				end
			end else begin
				if (old[i])
					r.up_mask[i] = 1'b1;
				rep_tmr[i] = '0;
			end
		end
		r.ctrl_held  = f.keyboard_present & (|f.modifier_keys[1:0]);
		r.alt_held   = f.keyboard_present & (|f.modifier_keys[3:2]);
		r.shift_held = f.keyboard_present & (|f.modifier_keys[5:4]);
		return r;
	endfunction

	function automatic int unsigned pick_gap(input bit on);
		int unsigned r;
		if (!on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic push_frame(input logic [2:0] btn,
			input logic [mbq_pkg::ELAPSED_W-1:0] dt,
			input logic kb, input logic [mbq_pkg::MOD_W-1:0] mods);
		mbq_pkg::frame_t f;
		f.pressed_buttons = btn;
		f.elapsed_ms = dt;
		f.keyboard_present = kb;
		f.modifier_keys = mods;
		frame_q = {frame_q, f};
	endtask

	task automatic write_reg(input logic [mbq_pkg::CFG_IDX_W-1:0] idx,
			input logic [mbq_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		unique case (idx)
			mbq_pkg::REG_DCLICK_WINDOW: win_ms = val;
			mbq_pkg::REG_REPEAT_FIRST: first_ms = val;
			mbq_pkg::REG_REPEAT_INTVL: intvl_ms = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (frame_q.size() != 0 || frames_ch.valid || due_events.size() != 0);
	endtask

	// frame driver
	always @(posedge clk) begin
		if (!arst_n) begin
			frames_ch.valid <= 1'b0;
			send_gap <= 0;
		end else if (!frames_ch.valid || frames_ch.ready) begin
			if (send_gap != 0) begin
				frames_ch.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (frame_q.size() != 0) begin
				frames_ch.valid <= 1'b1;
				frames_ch.payload <= frame_q.pop_front();
				send_gap <= pick_gap(src_idle);
			end else begin
				frames_ch.valid <= 1'b0;
			end
		end
	end

	// result sink with random stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			results_ch.ready <= 1'b0;
			sink_stall <= 0;
		end else if (sink_stall != 0) begin
			results_ch.ready <= 1'b0;
			sink_stall <= sink_stall - 1;
		end else if (sink_idle && $urandom_range(0, 99) < 25) begin
			results_ch.ready <= 1'b0;
			sink_stall <= pick_gap(1'b1);
		end else begin
			results_ch.ready <= 1'b1;
		end
	end

	// monitor: check each result word, then predict for each accepted frame
	always @(posedge clk) begin : monitor
		mbq_pkg::result_t got, want, fresh;
		if (arst_n) begin
			if (results_ch.valid && results_ch.ready) begin
				got = results_ch.payload;
				if (due_events.size() == 0) begin
					$error("result word with no frame outstanding: %h", got);
					mismatch_count++;
				end else begin
					want = due_events.pop_front();
					result_count++;
					if (got.held_mask !== want.held_mask) begin
						$error("held_mask: expected %0h, got %0h", want.held_mask, got.held_mask);
						mismatch_count++;
					end
					if (got.down_mask !== want.down_mask) begin
						$error("down_mask: expected %0h, got %0h", want.down_mask, got.down_mask);
						mismatch_count++;
					end
					if (got.up_mask !== want.up_mask) begin
						$error("up_mask: expected %0h, got %0h", want.up_mask, got.up_mask);
						mismatch_count++;
					end
					if (got.double_click_mask !== want.double_click_mask) begin
						$error("double_click_mask: expected %0h, got %0h",
							want.double_click_mask, got.double_click_mask);
						mismatch_count++;
					end
					if (got.repeat_mask !== want.repeat_mask) begin
						$error("repeat_mask: expected %0h, got %0h",
							want.repeat_mask, got.repeat_mask);
						mismatch_count++;
					end
					if (got.ctrl_held !== want.ctrl_held) begin
						$error("ctrl_held: expected %0b, got %0b", want.ctrl_held, got.ctrl_held);
						mismatch_count++;
					end
					if (got.alt_held !== want.alt_held) begin
						$error("alt_held: expected %0b, got %0b", want.alt_held, got.alt_held);
						mismatch_count++;
					end
					if (got.shift_held !== want.shift_held) begin
						$error("shift_held: expected %0b, got %0b", want.shift_held, got.shift_held);
						mismatch_count++;
					end
				end
			end
			if (frames_ch.valid && frames_ch.ready) begin
				fresh = qualify_frame(frames_ch.payload);
				due_events = {due_events, fresh};
				n_down += $countones(fresh.down_mask);
				n_up += $countones(fresh.up_mask);
				n_dclick += $countones(fresh.double_click_mask);
				n_repeat += $countones(fresh.repeat_mask);
			end
		end
	end

	initial begin : stimulus
		logic [mbq_pkg::CFG_W-1:0]     w, f, iv;
		logic [mbq_pkg::ELAPSED_W-1:0] dt;
		logic [2:0]                    btn;
		int unsigned                   left, chunk, r;

		frames_ch.valid = 1'b0;
		frames_ch.payload = '0;
		results_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		win_ms = mbq_pkg::DCLICK_WINDOW_RESET;
		first_ms = mbq_pkg::REPEAT_FIRST_RESET;
		intvl_ms = mbq_pkg::REPEAT_INTVL_RESET;
		prev_btn = '0;
		last_btn = '0;
		dclick_tmr = '0;
		for (int i = 0; i < 3; i++)
			rep_tmr[i] = '0;
		src_idle = 1'b0;
		sink_idle = 1'b0;
		stim_btn = '0;
		setting_count = 1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed frames at reset register values
		@(negedge clk);
		push_frame(3'b000, 16'd0, 1'b0, 6'h00);
		push_frame(3'b001, 16'd0, 1'b1, 6'h01);
		push_frame(3'b001, 16'd100, 1'b1, 6'h02);
		push_frame(3'b001, 16'd400, 1'b1, 6'h04);
		push_frame(3'b000, 16'd10, 1'b1, 6'h08);
		push_frame(3'b001, 16'd10, 1'b1, 6'h10);
		push_frame(3'b000, 16'd5, 1'b1, 6'h20);
		push_frame(3'b001, 16'd5, 1'b0, 6'h3f);
		push_frame(3'b000, 16'd0, 1'b1, 6'h00);
		push_frame(3'b001, 16'hffff, 1'b1, 6'h3f);
		push_frame(3'b011, 16'd1, 1'b1, 6'h15);
		push_frame(3'b111, 16'd1, 1'b1, 6'h2a);
		push_frame(3'b000, 16'd1, 1'b1, 6'h00);
		push_frame(3'b100, 16'd1, 1'b0, 6'h00);
		push_frame(3'b111, 16'hffff, 1'b1, 6'h03);
		push_frame(3'b111, 16'd66, 1'b1, 6'h0c);
		push_frame(3'b000, 16'd0, 1'b1, 6'h30);
		wait_drained();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin w = 16'd0; f = 16'd0; iv = 16'd0; end
				1: begin w = 16'hffff; f = 16'hffff; iv = 16'hffff; end
				2: begin
					w = 16'($urandom_range(20, 300));
					f = 16'($urandom_range(0, 200));
					iv = 16'($urandom_range(0, 100));
				end
				3: begin w = 16'd1; f = 16'd1; iv = 16'd1; end
				4: begin
					w = 16'($urandom());
					f = 16'($urandom());
					iv = 16'($urandom());
				end
				default: begin w = 16'd500; f = 16'd500; iv = 16'd66; end
			endcase
			write_reg(mbq_pkg::REG_DCLICK_WINDOW, w);
			write_reg(mbq_pkg::REG_REPEAT_FIRST, f);
			write_reg(mbq_pkg::REG_REPEAT_INTVL, iv);
			if (ph == 2 || ph == 5)
				write_reg(REG_UNUSED, 16'($urandom()));
			setting_count++;

			left = 255;
			while (left > 0) begin
				chunk = $urandom_range(15, 60);
				if (chunk > left)
					chunk = left;
				@(negedge clk);
				src_idle = $urandom_range(0, 3) != 0;
				sink_idle = $urandom_range(0, 3) != 0;
				for (int k = 0; k < chunk; k++) begin
					r = $urandom_range(0, 99);
					if (r < 40)
						btn = stim_btn;
					else if (r < 85)
						btn = stim_btn ^ (3'b001 << $urandom_range(0, 2));
					else
						btn = 3'($urandom_range(0, 7));
					stim_btn = btn;
					r = $urandom_range(0, 99);
					if (r < 70)
						dt = 16'($urandom_range(0, 40));
					else if (r < 90)
						dt = 16'($urandom_range(0, 600));
					else if (r < 97)
						dt = 16'($urandom());
					else
						dt = 16'hffff;
					push_frame(btn, dt, $urandom_range(0, 99) < 85,
						6'($urandom_range(0, 63)));
				end
				left -= chunk;
				// at random, hold the sender until the block has emptied
				if ($urandom_range(0, 3) == 0)
					wait_drained();
			end
			wait_drained();
		end

		repeat (6) @(posedge clk);
		$display("checked %0d result words over %0d register settings", result_count,
			setting_count);
		$display("events seen: %0d down, %0d double click, %0d up, %0d repeat",
			n_down, n_dclick, n_up, n_repeat);
		if (mismatch_count == 0 && due_events.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
